[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GBE_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication.
`define GBE_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[rtl/gbe_pkg.sv]
// ---------------------------------------------------------------------------
// gbe_pkg
// Types and constants shared by the gamepad edge and auto-repeat block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbe_pkg;

  // Default count of ports, and maximum count of records per collect.
  localparam int PORTS_DEF = 4;
  localparam int MAXREC    = 4;

  // Reset values of the configuration registers.
  localparam logic [7:0] DELAY_RESET    = 8'd30;
  localparam logic [7:0] INTERVAL_RESET = 8'd5;

  localparam int CD_W      = 9;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 1'd1;

  // Request codes.
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_COLLECT = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        port;
    logic              link_error;
    logic [15:0]       buttons;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        out_port;
    logic [15:0]       hold;
    logic [15:0]       tap;
    logic [15:0]       release_res;
    logic [15:0]       repeat_res;
    logic signed [7:0] pub_stick_x;
    logic signed [7:0] pub_stick_y;
    logic              connected;
    logic [2:0]        connected_count;
    logic [1:0]        main_port;
    logic              main_valid;
    logic              last;
  } out_word_t;

  // Published record of one port.
  typedef struct packed {
    logic [15:0]       hold;
    logic [15:0]       tap;
    logic [15:0]       rel;
    logic [15:0]       rep;
    logic signed [7:0] sx;
    logic signed [7:0] sy;
  } pub_rec_t;

  // Per-port update strobes.
  typedef struct packed {
    logic sample_we;
    logic collect_we;
  } port_ctl_t;

  // Collect summary handed to the emitter.
  typedef struct packed {
    logic              start;
    logic [MAXREC-1:0] conn;
    logic [2:0]        count;
    logic [1:0]        main_port;
    logic              found;
  } emit_start_t;

endpackage

[rtl/gbe_port_unit.sv]
// ---------------------------------------------------------------------------
// gbe_port_unit
// State of one gamepad port: edge detection, repeat countdown, accumulators
// and the published record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbe_port_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  gbe_pkg::port_ctl_t ctl,
  input  gbe_pkg::in_word_t  smp,
  input  logic [7:0]        initial_delay,
  input  logic [7:0]        repeat_interval,
  output logic              connected,
  output gbe_pkg::pub_rec_t pub
);

  logic [15:0]              held_r, held_nxt;
  logic [gbe_pkg::CD_W-1:0] cd_r, cd_nxt;
  logic [15:0]              tap_r, tap_nxt;
  logic [15:0]              rel_r, rel_nxt;
  logic [15:0]              rep_r, rep_nxt;
  logic signed [7:0]        sx_r, sx_nxt;
  logic signed [7:0]        sy_r, sy_nxt;
  logic                     err_r, err_nxt;
  gbe_pkg::pub_rec_t        pub_r, pub_nxt;

  logic [15:0] diff, press, rls, strobe;

  // Edge detection and repeat countdown for a good sample, and publishing at a collect.
  always_comb begin
    diff     = smp.buttons ^ held_r;
    press    = diff & smp.buttons;
    rls      = diff & held_r;
    held_nxt = held_r;
    cd_nxt   = cd_r;
    tap_nxt  = tap_r;
    rel_nxt  = rel_r;
    rep_nxt  = rep_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    err_nxt  = err_r;
    pub_nxt  = pub_r;
    strobe   = '0;
    if (diff != 16'd0) begin
      strobe = press;
    end else if (cd_r <= 9'd1) begin
      strobe = smp.buttons;
    end
    if (ctl.sample_we) begin
      err_nxt = smp.link_error;
      if (!smp.link_error) begin
        if (diff != 16'd0) begin
          cd_nxt = {1'b0, initial_delay};
        end else if (cd_r <= 9'd1) begin
          cd_nxt = {1'b0, repeat_interval};
        end else begin
          cd_nxt = cd_r - 9'd1;
        end
        held_nxt = smp.buttons;
        sx_nxt   = smp.stick_x;
        sy_nxt   = smp.stick_y;
        tap_nxt  = tap_r | press;
        rel_nxt  = rel_r | rls;
        rep_nxt  = rep_r | strobe;
      end
    end else if (ctl.collect_we && !err_r) begin
      // Publish and clear the accumulators of a connected port.
      pub_nxt.hold = held_r;
      pub_nxt.tap  = tap_r;
      pub_nxt.rel  = rel_r;
      pub_nxt.rep  = rep_r;
      pub_nxt.sx   = sx_r;
      pub_nxt.sy   = sy_r;
      tap_nxt      = '0;
      rel_nxt      = '0;
      rep_nxt      = '0;
    end
  end

  // Port state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cd_r   <= {1'b0, gbe_pkg::DELAY_RESET};
      tap_r  <= '0;
      rel_r  <= '0;
      rep_r  <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      err_r  <= 1'b1;
      pub_r  <= '0;
    end else begin
      held_r <= held_nxt;
      cd_r   <= cd_nxt;
      tap_r  <= tap_nxt;
      rel_r  <= rel_nxt;
      rep_r  <= rep_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      err_r  <= err_nxt;
      pub_r  <= pub_nxt;
    end
  end

  assign connected = !err_r;
  assign pub       = pub_r;

endmodule

[rtl/gbe_emitter.sv]
// ---------------------------------------------------------------------------
// gbe_emitter
// Sends the published records of one collect through the output register,
// one word a cycle while out_stall is low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbe_emitter #(
  parameter int PORTS = gbe_pkg::PORTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gbe_pkg::emit_start_t                  go,
  input  gbe_pkg::pub_rec_t [gbe_pkg::MAXREC-1:0] recs,
  output logic                                  busy,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output gbe_pkg::out_word_t                    out_word
);

  localparam int NREC = (PORTS < gbe_pkg::MAXREC) ? PORTS : gbe_pkg::MAXREC;
  localparam logic [1:0] LAST_IDX = 2'(NREC - 1);

  logic                      busy_r, busy_nxt;
  logic [1:0]                idx_r, idx_nxt;
  logic [gbe_pkg::MAXREC-1:0] conn_r, conn_nxt;
  logic [2:0]                count_r, count_nxt;
  logic [1:0]                main_r, main_nxt;
  logic                      found_r, found_nxt;
  logic                      ov_r, ov_nxt;
  gbe_pkg::out_word_t        ow_r, ow_nxt;
  logic                      load;

  // Record sequencer and output register control.
  always_comb begin
    load      = busy_r && (!ov_r || !out_stall);
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    conn_nxt  = conn_r;
    count_nxt = count_r;
    main_nxt  = main_r;
    found_nxt = found_r;
    ov_nxt    = ov_r;
    ow_nxt    = ow_r;
    if (!out_stall) begin
      ov_nxt = 1'b0;
    end
    if (go.start) begin
      // Snapshot the connection summary at the collect.
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      conn_nxt  = go.conn;
      count_nxt = go.count;
      main_nxt  = go.main_port;
      found_nxt = go.found;
    end else if (load) begin
      ov_nxt                 = 1'b1;
      ow_nxt.out_port        = idx_r;
      ow_nxt.hold            = recs[idx_r].hold;
      ow_nxt.tap             = recs[idx_r].tap;
      ow_nxt.release_res     = recs[idx_r].rel;
      ow_nxt.repeat_res      = recs[idx_r].rep;
      ow_nxt.pub_stick_x     = recs[idx_r].sx;
      ow_nxt.pub_stick_y     = recs[idx_r].sy;
      ow_nxt.connected       = conn_r[idx_r];
      ow_nxt.connected_count = count_r;
      ow_nxt.main_port       = main_r;
      ow_nxt.main_valid      = found_r;
      ow_nxt.last            = (idx_r == LAST_IDX);
      idx_nxt                = idx_r + 2'd1;
      if (idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control registers take reset; the payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    conn_r  <= conn_nxt;
    count_r <= count_nxt;
    main_r  <= main_nxt;
    found_r <= found_nxt;
    ow_r    <= ow_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule

[rtl/gamepad_button_edge_repeat.sv]
// One word is accepted every cycle unless a waiting collect stalls the
// input. A sample word updates its port's edge and repeat state from the
// input register and produces no result. A collect word publishes every
// connected port, then the record sequencer sends min(PORTS, 4) result
// words through the output register on consecutive cycles while out_stall
// is low; out_stall holds each word in place. Samples keep flowing
// meanwhile, while a following collect waits in the input register until
// the sequencer has loaded the last word of the previous collect.
// ---------------------------------------------------------------------------
// gamepad_button_edge_repeat
// Button edge detection with auto-repeat for several gamepad ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gamepad_button_edge_repeat #(
  parameter int PORTS = gbe_pkg::PORTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gbe_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gbe_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [gbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);

  // Ports that have a record slot in the sequencer.
  localparam int NLIVE = (PORTS < gbe_pkg::MAXREC) ? PORTS : gbe_pkg::MAXREC;

  logic              in_valid_r, in_valid_nxt;
  gbe_pkg::in_word_t in_r, in_nxt;
  logic [7:0]        delay_r, delay_nxt;
  logic [7:0]        interval_r, interval_nxt;

  logic                   accept, consume, is_collect, emit_busy;
  logic [PORTS-1:0]       conn;
  gbe_pkg::pub_rec_t      pub [PORTS];
  gbe_pkg::pub_rec_t [gbe_pkg::MAXREC-1:0] recs;
  gbe_pkg::emit_start_t   go;

  // Input register: a sample always drains, a collect waits for the sequencer.
  assign is_collect = (in_r.req_type == gbe_pkg::REQ_COLLECT);
  assign consume    = in_valid_r && (!is_collect || !emit_busy);
  assign in_stall   = in_valid_r && !consume;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_nxt       = in_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
      in_nxt       = in_word;
    end else if (consume) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Configuration writes.
  always_comb begin
    delay_nxt    = delay_r;
    interval_nxt = interval_r;
    if (cfg_we) begin
      case (cfg_index)
        gbe_pkg::REG_INITIAL_DELAY:   delay_nxt    = cfg_wdata;
        gbe_pkg::REG_REPEAT_INTERVAL: interval_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      delay_r    <= gbe_pkg::DELAY_RESET;
      interval_r <= gbe_pkg::INTERVAL_RESET;
    end else begin
      in_valid_r <= in_valid_nxt;
      delay_r    <= delay_nxt;
      interval_r <= interval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
  end

  // Per-port state.
  for (genvar i = 0; i < PORTS; i++) begin : g_port
    gbe_pkg::port_ctl_t ctl;
    assign ctl.sample_we  = consume && !is_collect && ({1'b0, in_r.port} == 3'(i));
    assign ctl.collect_we = consume && is_collect;
    gbe_port_unit u_port (
      .clk             (clk),
      .rst_n           (rst_n),
      .ctl             (ctl),
      .smp             (in_r),
      .initial_delay   (delay_r),
      .repeat_interval (interval_r),
      .connected       (conn[i]),
      .pub             (pub[i])
    );
  end

  // Records visible to the sequencer; ports past PORTS are never sent.
  for (genvar k = 0; k < gbe_pkg::MAXREC; k++) begin : g_rec
    if (k < PORTS) begin : g_live
      assign recs[k] = pub[k];
    end else begin : g_none
      assign recs[k] = '0;
    end
  end

  // Connection summary: per-record flags, count and lowest connected port.
  always_comb begin
    go.conn = '0;
    for (int k = 0; k < NLIVE; k++) begin
      go.conn[k] = conn[k];
    end
    go.main_port = '0;
    for (int p = PORTS - 1; p >= 0; p--) begin
      if (conn[p]) begin
        go.main_port = 2'(p);
      end
    end
    go.found = |conn;
    go.count = 3'($countones(conn));
    go.start = consume && is_collect;
  end

  gbe_emitter #(
    .PORTS (PORTS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .recs      (recs),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // A collect that drains always starts the record sequencer.
  `GBE_ASSERT_NXT(a_collect_starts, clk, rst_n, go.start, emit_busy)
  // Back-pressure on the input only ever comes from a waiting collect.
  `GBE_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, in_valid_r && is_collect && emit_busy)
  // Summary fields of a result word agree with each other.
  `GBE_ASSERT_IMP(a_summary, clk, rst_n, out_valid,
                  out_word.main_valid == (out_word.connected_count != 3'd0))

endmodule
